[hw/rtl/nca_pkg.sv]
// Shared types and constants of the nearest-centroid assignment block.
// No dependencies; imported by every module of the block.
package nca_pkg;

    localparam int unsigned COORD_W     = 16;
    localparam int unsigned CIDX_W      = 3;
    localparam int unsigned DIM_W       = 2;
    localparam int unsigned PNUM_W      = 16;
    localparam int unsigned CLUSTER_W   = 3;
    localparam int unsigned DIFF_W      = COORD_W + 1;
    localparam int unsigned SQ_W        = 2 * DIFF_W;
    localparam int unsigned DIST_W      = 38;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned M_TDATA_W   = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_FIND,
        ST_DONE
    } nca_state_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } nca_op_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic find_en;
        logic find_first;
    } nca_ctrl_t;

endpackage

[hw/rtl/nearest_centroid_assign.sv]
// Top level of the k-means assignment step: handshake, sequencer, centroid memory
// and result register. Depends on nca_pkg and nca_dist.
//
// A load request writes one centroid coordinate without stalling the input. A
// point coordinate with an in-range dim_index holds off the next request until
// its accumulate pass ends: one subtract-square-accumulate unit visits the
// centroids one per cycle through the single read port of the centroid memory,
// pipelined through the memory read register and the square register. A tlast
// coordinate then adds the argmin pass over the running distances and the result
// hand-off, which waits while m_tready holds the result register. The result
// register frees the input side while a result waits. Centroid memory contents are
// undefined after reset; every centroid coordinate must be loaded before use.
module nearest_centroid_assign #(
    parameter int unsigned NUM_CLUSTERS     = 8,
    parameter int unsigned NUM_DIMS         = 4,
    parameter int unsigned POINT_INDEX_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // centroid_index [2:0], dim_index [4:3], coord_value [20:5], zero [23:21]
    input  logic [nca_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // point_number [15:0], cluster [18:16], zero [23:19]
    output logic [nca_pkg::M_TDATA_W-1:0]     m_tdata
);
    import nca_pkg::*;

    localparam int unsigned IDX_W = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
    localparam int unsigned DEPTH = NUM_CLUSTERS * NUM_DIMS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_CLUSTERS + 2);
    localparam logic [CNT_W-1:0] CNT_LAST_RD  = CNT_W'(NUM_CLUSTERS - 1);
    localparam logic [CNT_W-1:0] CNT_ACC_END  = CNT_W'(NUM_CLUSTERS + 1);
    localparam logic [CNT_W-1:0] CNT_NCLUST   = CNT_W'(NUM_CLUSTERS);

    nca_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [COORD_W-1:0]   coord_reg;
    logic [DIM_W-1:0]            dim_reg;
    logic                        last_reg;
    logic signed [COORD_W-1:0]   cdata_reg;
    logic [COORD_W-1:0]          mem [DEPTH];
    logic [POINT_INDEX_BITS-1:0] pcount_reg;
    logic                        m_tvalid_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    logic [CIDX_W-1:0]           in_cidx;
    logic [DIM_W-1:0]            in_dim;
    logic [COORD_W-1:0]          in_coord;
    logic                        accept;
    logic                        in_load;
    logic                        in_point;
    logic                        dim_ok;
    logic                        load_ok;
    logic                        mem_we;
    logic                        rd_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic                        out_load;
    nca_ctrl_t                   ctrl;
    logic [IDX_W-1:0]            best_idx;

    assign in_cidx  = s_tdata[CIDX_W-1:0];
    assign in_dim   = s_tdata[CIDX_W+DIM_W-1:CIDX_W];
    assign in_coord = s_tdata[CIDX_W+DIM_W+COORD_W-1:CIDX_W+DIM_W];

    assign accept   = s_tvalid && s_tready;
    assign in_load  = accept && (nca_op_t'(s_tuser) == OP_LOAD);
    assign in_point = accept && (nca_op_t'(s_tuser) == OP_POINT);
    assign dim_ok   = 32'(in_dim) < NUM_DIMS;
    assign load_ok  = dim_ok && (32'(in_cidx) < NUM_CLUSTERS);
    assign wr_addr  = AW'(32'(in_cidx) * NUM_DIMS + 32'(in_dim));
    assign rd_addr  = AW'(32'(cnt_reg) * NUM_DIMS + 32'(dim_reg));
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_point) begin
                    if (dim_ok) begin
                        state_next = ST_ACCUM;
                    end else if (s_tlast) begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_ACCUM: begin
                if (cnt_reg == CNT_ACC_END) begin
                    cnt_next   = '0;
                    state_next = last_reg ? ST_FIND : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIND: begin
                if (cnt_reg == CNT_LAST_RD) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        ctrl            = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                mem_we   = in_load && load_ok;
            end
            ST_ACCUM: begin
                rd_en       = cnt_reg < CNT_NCLUST;
                ctrl.mul_en = (cnt_reg != '0) && (cnt_reg <= CNT_NCLUST);
                ctrl.acc_en = cnt_reg >= CNT_W'(2);
            end
            ST_FIND: begin
                ctrl.find_en    = 1'b1;
                ctrl.find_first = cnt_reg == '0;
            end
            ST_DONE: begin
                ctrl = '0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_point) begin
            coord_reg <= in_coord;
            dim_reg   <= in_dim;
            last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_coord;
        end
        if (rd_en) begin
            cdata_reg <= mem[rd_addr];
        end
    end

    nca_dist #(
        .NUM_CLUSTERS (NUM_CLUSTERS),
        .IDX_W        (IDX_W)
    ) u_nca_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .coord    (coord_reg),
        .cdata    (cdata_reg),
        .find_idx (cnt_reg[IDX_W-1:0]),
        .best_idx (best_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pcount_reg   <= '0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
            pcount_reg   <= pcount_reg + 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({CLUSTER_W'(best_idx), PNUM_W'(pcount_reg)});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/nca_dist.sv]
// Shared subtract-square-accumulate unit, running distance ring and argmin.
// Depends on nca_pkg; sequenced by nearest_centroid_assign.
module nca_dist #(
    parameter int unsigned NUM_CLUSTERS = 8,
    parameter int unsigned IDX_W        = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nca_pkg::nca_ctrl_t                    ctrl,
    input  logic signed [nca_pkg::COORD_W-1:0]    coord,
    input  logic signed [nca_pkg::COORD_W-1:0]    cdata,
    input  logic        [IDX_W-1:0]               find_idx,
    output logic        [IDX_W-1:0]               best_idx
);
    import nca_pkg::*;

    logic        [DIST_W-1:0]  ring_reg [NUM_CLUSTERS];
    logic        [SQ_W-1:0]    sq_reg;
    logic        [DIST_W-1:0]  best_reg;
    logic        [IDX_W-1:0]   best_idx_reg;
    logic signed [DIFF_W-1:0]  diff;
    logic        [DIST_W:0]    sum;
    logic        [DIST_W-1:0]  tail_val;
    logic        [DIST_W-1:0]  head;

    assign head = ring_reg[0];
    assign diff = DIFF_W'(coord) - DIFF_W'(cdata);
    assign sum  = {1'b0, head} + (DIST_W + 1)'(sq_reg);

    always_comb begin
        if (ctrl.find_en) begin
            tail_val = '0;
        end else if (sum[DIST_W]) begin
            tail_val = '1;
        end else begin
            tail_val = sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            sq_reg <= SQ_W'(diff * diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLUSTERS; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (ctrl.acc_en || ctrl.find_en) begin
            for (int i = 0; i < NUM_CLUSTERS - 1; i++) begin
                ring_reg[i] <= ring_reg[i+1];
            end
            ring_reg[NUM_CLUSTERS-1] <= tail_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.find_en && (ctrl.find_first || (head < best_reg))) begin
            best_reg     <= head;
            best_idx_reg <= find_idx;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

[hw/rtl/nca_check.sv]
// Port-level checker for nearest_centroid_assign, with its bind statement.
// Depends on nca_pkg and the top level's port list.
module nca_check #(
    parameter int unsigned NUM_CLUSTERS = 8,
    parameter int unsigned NUM_DIMS     = 4
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [nca_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nca_pkg::M_TDATA_W-1:0] m_tdata
);
    import nca_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result request dropped or changed while stalled");

    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("load request stalled the input");

    a_point_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && (32'(s_tdata[4:3]) < NUM_DIMS) |=> !s_tready)
        else $error("point coordinate did not occupy the distance unit");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an argmin pass");

    a_cluster_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[18:16]) < NUM_CLUSTERS)
        else $error("cluster index out of range");

endmodule

bind nearest_centroid_assign nca_check #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .NUM_DIMS     (NUM_DIMS)
) u_nca_check (.*);
